/* hw/rtl/argtok_pkg.sv */
package argtok_pkg;

  // Default for the argument limit
  localparam int MAX_ARGS_DEF = 4;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 2;
  localparam int COUNT_W = 3;
  localparam int DIGIT_W = 4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  // Letter a/A has low nibble 1, so adding 9 gives its digit value
  localparam logic [DIGIT_W-1:0] LETTER_OFS = 4'd9;

  // Per-line state apart from the argument position
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               digits_seen;
    logic               radix_hex;
    logic               zero_pending;
    logic               overflowed;
  } line_st_t;

  // One result request
  typedef struct packed {
    logic [VALUE_W-1:0] number_value;
    logic [INDEX_W-1:0] number_index;
    logic               number_valid;
    logic               line_done;
    logic [COUNT_W-1:0] number_count;
    logic               too_many;
  } res_t;

  // value * 16 or value * 10 as shift-add, wrapping at 32 bits
  function automatic logic [VALUE_W-1:0] mul_base(input logic [VALUE_W-1:0] v,
                                                 input logic hex);
    logic [VALUE_W-1:0] r;
    if (hex) begin
      r = v << 4;
    end else begin
      r = (v << 3) + (v << 1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/argtok_step.sv */
module argtok_step #(
  parameter int MAX_ARGS = argtok_pkg::MAX_ARGS_DEF,
  parameter int POS_W    = $clog2(MAX_ARGS + 1)
) (
  input  logic [argtok_pkg::CHAR_W-1:0] ch,
  input  argtok_pkg::line_st_t          st,
  input  logic [POS_W-1:0]              pos,
  input  logic                          default_hex,
  output argtok_pkg::line_st_t          st_nxt,
  output logic [POS_W-1:0]              pos_nxt,
  output argtok_pkg::res_t              res,
  output logic                          emit
);
  import argtok_pkg::*;

  logic [VALUE_W-1:0] acc_z;
  logic               ds_z;
  logic               x_taken;
  logic               is_space;
  logic               is_zero;
  logic               is_dec;
  logic               is_hexl;
  logic [DIGIT_W-1:0] digit;
  logic               keep;
  logic [POS_W-1:0]   pos_inc;

  // Resolve a pending zero: either the 0x prefix or a plain zero digit
  always_comb begin
    x_taken = 1'b0;
    acc_z   = st.acc;
    ds_z    = st.digits_seen;
    if (st.zero_pending) begin
      if (ch == CH_X) begin
        x_taken = 1'b1;
      end else begin
        acc_z = mul_base(st.acc, st.radix_hex);
        ds_z  = 1'b1;
      end
    end
  end

  // Character classes
  assign is_space = (ch == CH_SPACE);
  assign is_zero  = (ch == CH_ZERO);
  assign is_dec   = (ch >= CH_ONE) && (ch <= CH_NINE);
  assign is_hexl  = st.radix_hex &&
                    (((ch >= CH_LC_A) && (ch <= CH_LC_F)) ||
                     ((ch >= CH_UC_A) && (ch <= CH_UC_F)));
  assign digit    = is_dec ? ch[DIGIT_W-1:0] : ch[DIGIT_W-1:0] + LETTER_OFS;

  // Closing a number keeps it only while there is room
  assign keep    = ds_z && (pos < POS_W'(MAX_ARGS));
  assign pos_inc = pos + POS_W'(1);

  // Next state and result
  always_comb begin
    st_nxt              = st;
    st_nxt.zero_pending = 1'b0;
    pos_nxt             = pos;
    res                 = '0;
    emit                = 1'b0;
    priority if (x_taken) begin
      st_nxt.radix_hex   = 1'b1;
      st_nxt.acc         = mul_base(st.acc, 1'b1);
      st_nxt.digits_seen = 1'b1;
    end else if (is_space) begin
      st_nxt.acc         = ds_z ? '0 : acc_z;
      st_nxt.digits_seen = 1'b0;
      if (keep) begin
        emit             = 1'b1;
        res.number_value = acc_z;
        res.number_index = INDEX_W'(pos);
        res.number_valid = 1'b1;
        pos_nxt          = pos_inc;
      end else if (ds_z) begin
        st_nxt.overflowed = 1'b1;
      end
    end else if (is_zero) begin
      st_nxt.acc          = acc_z;
      st_nxt.digits_seen  = ds_z;
      st_nxt.zero_pending = 1'b1;
    end else if (is_dec || is_hexl) begin
      st_nxt.acc         = mul_base(acc_z, st.radix_hex) + VALUE_W'(digit);
      st_nxt.digits_seen = 1'b1;
    end else begin
      // Terminator: report pending number and count, then clear the line
      emit          = 1'b1;
      res.line_done = 1'b1;
      if (keep) begin
        res.number_value = acc_z;
        res.number_index = INDEX_W'(pos);
        res.number_valid = 1'b1;
        res.number_count = COUNT_W'(pos_inc);
      end else begin
        res.number_count = COUNT_W'(pos);
      end
      res.too_many        = st.overflowed || (ds_z && !keep);
      st_nxt.acc          = '0;
      st_nxt.digits_seen  = 1'b0;
      st_nxt.zero_pending = 1'b0;
      st_nxt.overflowed   = 1'b0;
      st_nxt.radix_hex    = default_hex;
      pos_nxt             = '0;
    end
  end

endmodule

/* hw/rtl/argument_number_tokenizer.sv */
// Pipeline: a character accepted from the input sits in the input register; a result
//   that it yields is loaded into the result register, stalling while the output is full.
// Throughput: one character per cycle while not stalled, set by the single-pass step logic.
// Reset: rst_n synchronous, active low; clears the line state and both
//   valid flags, and sets the default radix to hexadecimal.
module argument_number_tokenizer #(
  parameter int MAX_ARGS = argtok_pkg::MAX_ARGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [argtok_pkg::CHAR_W-1:0]  in_char_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [argtok_pkg::VALUE_W-1:0] out_number_value,
  output logic [argtok_pkg::INDEX_W-1:0] out_number_index,
  output logic                           out_number_valid,
  output logic                           out_line_done,
  output logic [argtok_pkg::COUNT_W-1:0] out_number_count,
  output logic                           out_too_many
);
  import argtok_pkg::*;

  localparam int POS_W = $clog2(MAX_ARGS + 1);

  logic              s1_vld_r;
  logic [CHAR_W-1:0] s1_char_r;
  line_st_t          st_r;
  line_st_t          st_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              dflt_hex_r;
  res_t              res_nxt;
  res_t              res_r;
  logic              emit;
  logic              out_valid_r;
  logic              out_free;
  logic              s1_adv;
  logic              line_fresh;

  // Step logic for the character in the input register
  argtok_step #(
    .MAX_ARGS (MAX_ARGS),
    .POS_W    (POS_W)
  ) u_step (
    .ch          (s1_char_r),
    .st          (st_r),
    .pos         (pos_r),
    .default_hex (dflt_hex_r),
    .st_nxt      (st_nxt),
    .pos_nxt     (pos_nxt),
    .res         (res_nxt),
    .emit        (emit)
  );

  // Flow control: characters without a result never wait on the output
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_vld_r && (out_free || !emit);
  assign in_ready = !s1_vld_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_in;
    end
  end

  // Nothing taken in this line yet: a config write reloads the radix if no character advances
  assign line_fresh = (pos_r == '0) && !st_r.digits_seen &&
                      !st_r.zero_pending && !st_r.overflowed;

  // Line state and default radix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '{acc: '0, digits_seen: 1'b0, radix_hex: 1'b1,
                      zero_pending: 1'b0, overflowed: 1'b0};
      pos_r      <= '0;
      dflt_hex_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        dflt_hex_r <= cfg_wr_data;
      end
      if (s1_adv) begin
        st_r  <= st_nxt;
        pos_r <= pos_nxt;
      end else if (cfg_wr_en && line_fresh) begin
        st_r.radix_hex <= cfg_wr_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_number_value = res_r.number_value;
  assign out_number_index = res_r.number_index;
  assign out_number_valid = res_r.number_valid;
  assign out_line_done    = res_r.line_done;
  assign out_number_count = res_r.number_count;
  assign out_too_many     = res_r.too_many;

`ifndef ASSERT_OFF
  // Every result carries a number or a line end
  a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.number_valid || res_r.line_done))
    else $error("result with neither number nor line end");

  // Argument position never passes the limit
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_ARGS))
    else $error("argument position beyond limit");

  // A line end clears the line state
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit && res_nxt.line_done) |=>
      (pos_r == '0 && !st_r.digits_seen && !st_r.overflowed && !st_r.zero_pending))
    else $error("line state not cleared after line end");

  // A 0x prefix switches the line to hex
  a_hex_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && st_r.zero_pending && s1_char_r == CH_X) |=> st_r.radix_hex)
    else $error("0x prefix did not select hex");

  // An empty number slot reads as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.number_valid) |->
      (res_r.number_value == '0 && res_r.number_index == '0))
    else $error("number fields not zero without a number");
`endif

endmodule
